@@ hdl/htc_pkg.sv @@
package htc_pkg;

    localparam int LEVER_ARM_MM    = 120;
    localparam int WHEEL_RADIUS_MM = 30;
    localparam int PI_Q13          = 25736;
    localparam int HALF_PI_Q13     = 12868;
    localparam int ONE_Q15         = 32768;

    // wheel speed divide by a constant through a scaled reciprocal
    localparam int SPEED_DEN   = WHEEL_RADIUS_MM * 16;
    localparam int DEN_HALF    = SPEED_DEN / 2;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP       = (1 << RECIP_SHIFT) / SPEED_DEN;
    localparam int X_W         = 28;
    localparam int Q_W         = X_W - 4;

    localparam logic [15:0] RST_TARGET_HEADING  = 16'd0;
    localparam logic        RST_REVERSE_MODE    = 1'b0;
    localparam logic [14:0] RST_STOP_TOLERANCE  = 15'd82;
    localparam logic [15:0] RST_HEADING_P_GAIN  = 16'd256;
    localparam logic [15:0] RST_HEADING_D_GAIN  = 16'd0;
    localparam logic [14:0] RST_TURN_RATE_LIMIT = 15'd2560;
    localparam logic [15:0] RST_WHEEL_P_GAIN    = 16'd256;
    localparam logic [15:0] RST_WHEEL_I_GAIN    = 16'd16;

    typedef enum logic [2:0] {
        REG_TARGET_HEADING,
        REG_REVERSE_MODE,
        REG_STOP_TOLERANCE,
        REG_HEADING_P_GAIN,
        REG_HEADING_D_GAIN,
        REG_TURN_RATE_LIMIT,
        REG_WHEEL_P_GAIN,
        REG_WHEEL_I_GAIN
    } htc_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_XR,
        ST_MUL_XL,
        ST_CORR_R,
        ST_CORR_L,
        ST_ERR_W,
        ST_MUL_IR,
        ST_MUL_PR,
        ST_MUL_IL,
        ST_MUL_PL,
        ST_PTERM_L,
        ST_SUM_L,
        ST_DONE
    } htc_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_PG_ERR,
        MUL_DG_DERR,
        MUL_RECIP_XR,
        MUL_RECIP_XL,
        MUL_IG_EWR,
        MUL_WP_EWR,
        MUL_IG_EWL,
        MUL_WP_EWL
    } htc_mul_t;

    typedef struct packed {
        logic     load_in;
        logic     calc_err;
        htc_mul_t mul_sel;
        logic     ld_acc;
        logic     ld_pd;
        logic     ld_wc;
        logic     ld_q0r;
        logic     ld_q0l;
        logic     corr_r;
        logic     corr_l;
        logic     calc_ew;
        logic     upd_ir;
        logic     upd_il;
        logic     ld_pterm;
        logic     sum_r;
        logic     sum_l;
        logic     out_load;
    } htc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } htc_status_t;

endpackage

@@ hdl/htc_controller.sv @@
module htc_controller import htc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  htc_status_t status,
    output htc_cmd_t    cmd
);

    htc_state_t state_reg;
    htc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.calc_err = 1'b1;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_sel = MUL_PG_ERR;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.mul_sel = MUL_DG_DERR;
                cmd.ld_acc  = 1'b1;
                state_next  = ST_MUL_XR;
            end
            ST_MUL_XR: begin
                cmd.mul_sel = MUL_RECIP_XR;
                cmd.ld_pd   = 1'b1;
                state_next  = ST_MUL_XL;
            end
            ST_MUL_XL: begin
                cmd.mul_sel = MUL_RECIP_XL;
                cmd.ld_q0r  = 1'b1;
                cmd.ld_wc   = 1'b1;
                state_next  = ST_CORR_R;
            end
            ST_CORR_R: begin
                cmd.ld_q0l = 1'b1;
                cmd.corr_r = 1'b1;
                state_next = ST_CORR_L;
            end
            ST_CORR_L: begin
                cmd.corr_l = 1'b1;
                state_next = ST_ERR_W;
            end
            ST_ERR_W: begin
                cmd.calc_ew = 1'b1;
                state_next  = ST_MUL_IR;
            end
            ST_MUL_IR: begin
                cmd.mul_sel = MUL_IG_EWR;
                state_next  = ST_MUL_PR;
            end
            ST_MUL_PR: begin
                cmd.mul_sel = MUL_WP_EWR;
                cmd.upd_ir  = 1'b1;
                state_next  = ST_MUL_IL;
            end
            ST_MUL_IL: begin
                cmd.mul_sel  = MUL_IG_EWL;
                cmd.ld_pterm = 1'b1;
                state_next   = ST_MUL_PL;
            end
            ST_MUL_PL: begin
                cmd.mul_sel = MUL_WP_EWL;
                cmd.sum_r   = 1'b1;
                cmd.upd_il  = 1'b1;
                state_next  = ST_PTERM_L;
            end
            ST_PTERM_L: begin
                cmd.ld_pterm = 1'b1;
                state_next   = ST_SUM_L;
            end
            ST_SUM_L: begin
                cmd.sum_l  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/htc_datapath.sv @@
module htc_datapath import htc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  htc_cmd_t    cmd,
    output htc_status_t status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic [63:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [0:0]  m_tuser
);

    localparam logic signed [16:0] PI_S      = 17'(PI_Q13);
    localparam logic signed [16:0] HALF_PI_S = 17'(HALF_PI_Q13);
    localparam logic signed [27:0] RECIP_B   = 28'(RECIP);
    localparam logic signed [45:0] ONE_S     = 46'(ONE_Q15);

    // configuration
    logic signed [15:0] target_heading_reg;
    logic               reverse_mode_reg;
    logic [14:0]        stop_tolerance_reg;
    logic [15:0]        heading_p_gain_reg;
    logic [15:0]        heading_d_gain_reg;
    logic [14:0]        turn_rate_limit_reg;
    logic [15:0]        wheel_p_gain_reg;
    logic [15:0]        wheel_i_gain_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_heading_reg  <= RST_TARGET_HEADING;
            reverse_mode_reg    <= RST_REVERSE_MODE;
            stop_tolerance_reg  <= RST_STOP_TOLERANCE;
            heading_p_gain_reg  <= RST_HEADING_P_GAIN;
            heading_d_gain_reg  <= RST_HEADING_D_GAIN;
            turn_rate_limit_reg <= RST_TURN_RATE_LIMIT;
            wheel_p_gain_reg    <= RST_WHEEL_P_GAIN;
            wheel_i_gain_reg    <= RST_WHEEL_I_GAIN;
        end else if (cfg_valid) begin
            case (htc_reg_t'(cfg_addr))
                REG_TARGET_HEADING:  target_heading_reg  <= cfg_data;
                REG_REVERSE_MODE:    reverse_mode_reg    <= cfg_data[0];
                REG_STOP_TOLERANCE:  stop_tolerance_reg  <= cfg_data[14:0];
                REG_HEADING_P_GAIN:  heading_p_gain_reg  <= cfg_data;
                REG_HEADING_D_GAIN:  heading_d_gain_reg  <= cfg_data;
                REG_TURN_RATE_LIMIT: turn_rate_limit_reg <= cfg_data[14:0];
                REG_WHEEL_P_GAIN:    wheel_p_gain_reg    <= cfg_data;
                REG_WHEEL_I_GAIN:    wheel_i_gain_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input item
    logic               new_move_reg;
    logic signed [15:0] meas_reg;
    logic signed [15:0] vr_reg;
    logic signed [15:0] vl_reg;
    logic signed [15:0] w_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            new_move_reg <= s_tuser[0];
            meas_reg     <= s_tdata[15:0];
            vr_reg       <= s_tdata[31:16];
            vl_reg       <= s_tdata[47:32];
            w_reg        <= s_tdata[63:48];
        end
    end

    // heading error and wheel speed numerators
    logic signed [16:0] diff_c;
    logic signed [16:0] err_c;
    logic signed [16:0] prev_c;
    logic signed [17:0] derr_c;
    logic               flip_c;
    logic signed [29:0] lever_c;
    logic signed [29:0] num_r_c;
    logic signed [29:0] num_l_c;
    logic signed [29:0] abs_r_c;
    logic signed [29:0] abs_l_c;

    logic signed [16:0] last_err_reg;
    logic signed [16:0] err_reg;
    logic signed [17:0] derr_reg;
    logic [X_W-1:0]     xr_reg;
    logic [X_W-1:0]     xl_reg;
    logic               neg_r_reg;
    logic               neg_l_reg;

    always_comb begin
        diff_c = 17'(target_heading_reg) - 17'(meas_reg);
        flip_c = reverse_mode_reg && (diff_c > HALF_PI_S || diff_c < -HALF_PI_S);
        if (flip_c) begin
            err_c = (diff_c > 17'sd0) ? diff_c - PI_S : diff_c + PI_S;
        end else begin
            err_c = diff_c;
        end
        prev_c  = new_move_reg ? 17'sd0 : last_err_reg;
        derr_c  = 18'(err_c) - 18'(prev_c);
        lever_c = 30'($signed(w_reg) * LEVER_ARM_MM);
        num_r_c = $signed({{2{vr_reg[15]}}, vr_reg, 12'b0}) + lever_c;
        num_l_c = $signed({{2{vl_reg[15]}}, vl_reg, 12'b0}) - lever_c;
        abs_r_c = num_r_c[29] ? -num_r_c : num_r_c;
        abs_l_c = num_l_c[29] ? -num_l_c : num_l_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (cmd.calc_err) begin
            last_err_reg <= err_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_err) begin
            err_reg   <= err_c;
            derr_reg  <= derr_c;
            xr_reg    <= abs_r_c[X_W-1:0] + X_W'(DEN_HALF);
            xl_reg    <= abs_l_c[X_W-1:0] + X_W'(DEN_HALF);
            neg_r_reg <= num_r_c[29];
            neg_l_reg <= num_l_c[29];
        end
    end

    // shared multiplier, product registered
    logic signed [28:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [56:0] prod_reg;
    logic signed [26:0] ewr_reg;
    logic signed [26:0] ewl_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_PG_ERR: begin
                mul_a = $signed({13'b0, heading_p_gain_reg});
                mul_b = 28'(err_reg);
            end
            MUL_DG_DERR: begin
                mul_a = $signed({13'b0, heading_d_gain_reg});
                mul_b = 28'(derr_reg);
            end
            MUL_RECIP_XR: begin
                mul_a = $signed({1'b0, xr_reg});
                mul_b = RECIP_B;
            end
            MUL_RECIP_XL: begin
                mul_a = $signed({1'b0, xl_reg});
                mul_b = RECIP_B;
            end
            MUL_IG_EWR: begin
                mul_a = $signed({13'b0, wheel_i_gain_reg});
                mul_b = 28'(ewr_reg);
            end
            MUL_WP_EWR: begin
                mul_a = $signed({13'b0, wheel_p_gain_reg});
                mul_b = 28'(ewr_reg);
            end
            MUL_IG_EWL: begin
                mul_a = $signed({13'b0, wheel_i_gain_reg});
                mul_b = 28'(ewl_reg);
            end
            MUL_WP_EWL: begin
                mul_a = $signed({13'b0, wheel_p_gain_reg});
                mul_b = 28'(ewl_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // heading pd term and turn rate clamp
    logic signed [34:0] acc_reg;
    logic signed [34:0] pd_reg;
    logic signed [15:0] wc_reg;
    logic signed [35:0] pd_rnd_c;
    logic signed [22:0] pd_sh_c;
    logic signed [22:0] lim_c;
    logic signed [22:0] wc_c;

    always_comb begin
        pd_rnd_c = 36'(pd_reg) + 36'sd4096;
        pd_sh_c  = 23'(pd_rnd_c >>> 13);
        lim_c    = $signed({8'b0, turn_rate_limit_reg});
        if (pd_sh_c > lim_c) begin
            wc_c = lim_c;
        end else if (pd_sh_c < -lim_c) begin
            wc_c = -lim_c;
        end else begin
            wc_c = pd_sh_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_acc) begin
            acc_reg <= $signed(prod_reg[34:0]);
        end
        if (cmd.ld_pd) begin
            pd_reg <= acc_reg + $signed(prod_reg[34:0]);
        end
        if (cmd.ld_wc) begin
            wc_reg <= 16'(wc_c);
        end
    end

    // measured wheel speeds: reciprocal estimate, then one correction step
    logic [Q_W-1:0]     q0r_reg;
    logic [Q_W-1:0]     q0l_reg;
    logic signed [25:0] act_r_reg;
    logic signed [25:0] act_l_reg;
    logic [Q_W-1:0]     corr_q0_c;
    logic [X_W-1:0]     corr_x_c;
    logic               corr_neg_c;
    logic [X_W-1:0]     corr_rem_c;
    logic [Q_W-1:0]     corr_q_c;
    logic signed [25:0] corr_qs_c;
    logic signed [25:0] act_c;

    always_comb begin
        corr_q0_c  = cmd.corr_l ? q0l_reg : q0r_reg;
        corr_x_c   = cmd.corr_l ? xl_reg : xr_reg;
        corr_neg_c = cmd.corr_l ? neg_l_reg : neg_r_reg;
        corr_rem_c = corr_x_c - X_W'(corr_q0_c * SPEED_DEN);
        corr_q_c   = corr_q0_c + Q_W'(corr_rem_c >= X_W'(SPEED_DEN));
        corr_qs_c  = $signed({2'b0, corr_q_c});
        act_c      = corr_neg_c ? -corr_qs_c : corr_qs_c;
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_q0r) begin
            q0r_reg <= prod_reg[RECIP_SHIFT +: Q_W];
        end
        if (cmd.ld_q0l) begin
            q0l_reg <= prod_reg[RECIP_SHIFT +: Q_W];
        end
        if (cmd.corr_r) begin
            act_r_reg <= act_c;
        end
        if (cmd.corr_l) begin
            act_l_reg <= act_c;
        end
        if (cmd.calc_ew) begin
            ewr_reg <= 27'(wc_reg) - 27'(act_r_reg);
            ewl_reg <= -27'(wc_reg) - 27'(act_l_reg);
        end
    end

    // wheel pi: integral with anti-windup, proportional term, output saturation
    logic signed [16:0] integ_r_reg;
    logic signed [16:0] integ_l_reg;
    logic signed [43:0] pterm_reg;
    logic signed [15:0] drive_r_reg;
    logic signed [15:0] drive_l_reg;
    logic signed [43:0] prod_rnd_c;
    logic signed [16:0] integ_old_c;
    logic signed [45:0] integ_sum_c;
    logic signed [16:0] integ_new_c;
    logic signed [16:0] integ_use_c;
    logic signed [44:0] dsum_c;
    logic signed [15:0] drive_c;

    always_comb begin
        prod_rnd_c  = 44'((45'($signed(prod_reg[43:0])) + 45'sd1) >>> 1);
        integ_old_c = cmd.upd_il ? integ_l_reg : integ_r_reg;
        integ_sum_c = 46'(integ_old_c) + 46'(prod_rnd_c);
        if (integ_sum_c > ONE_S) begin
            integ_new_c = 17'(ONE_S);
        end else if (integ_sum_c < -ONE_S) begin
            integ_new_c = 17'(-ONE_S);
        end else begin
            integ_new_c = 17'(integ_sum_c);
        end
        integ_use_c = cmd.sum_l ? integ_l_reg : integ_r_reg;
        dsum_c      = 45'(pterm_reg) + 45'(integ_use_c);
        if (dsum_c > 45'sd32767) begin
            drive_c = 16'sh7fff;
        end else if (dsum_c < -45'sd32768) begin
            drive_c = 16'sh8000;
        end else begin
            drive_c = 16'(dsum_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_r_reg <= '0;
            integ_l_reg <= '0;
        end else begin
            if (cmd.upd_ir) begin
                integ_r_reg <= integ_new_c;
            end
            if (cmd.upd_il) begin
                integ_l_reg <= integ_new_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_pterm) begin
            pterm_reg <= prod_rnd_c;
        end
        if (cmd.sum_r) begin
            drive_r_reg <= drive_c;
        end
        if (cmd.sum_l) begin
            drive_l_reg <= drive_c;
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [55:0] m_tdata_reg;
    logic        move_done_reg;
    logic [16:0] err_mag_c;

    assign err_mag_c     = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign m_tvalid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg   <= {7'b0, err_reg, drive_l_reg, drive_r_reg};
            move_done_reg <= (err_mag_c <= {2'b0, stop_tolerance_reg});
        end
    end

    assign status.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tuser         = move_done_reg;

endmodule

@@ hdl/heading_turn_controller_core.sv @@
// heading turn controller: one control tick per input item.
// s_ channel: one item per tick, tdata carries measured heading, right and
// left wheel linear speeds and body turn rate; tuser carries the new move flag.
// m_ channel: one result per input, tdata carries right drive, left drive and
// heading error; tuser carries the move done flag.
// cfg channel: cfg_addr selects one of eight registers, cfg_data is masked to
// the register width; cfg_ready is high out of reset. write only while idle.
// items are handled one at a time: the controller sequence runs eight products
// through the single shared multiplier plus the divide correction and
// saturation steps before the next item is accepted.
// s_tready is high only while the controller is idle; the next item can be
// taken while a finished result still waits in the output register.
// if the receiver stalls, the next result waits in its last step until the
// output register is taken, and then further input is held off.
// reset: registers return to their defaults, the previous heading error and
// both wheel integrals clear, no result is pending.
module heading_turn_controller_core import htc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // measured_heading, right_linear_speed, left_linear_speed, body_turn_rate
    input  logic [63:0] s_tdata,
    // new_move
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // right_drive, left_drive, heading_error, zero fill
    output logic [55:0] m_tdata,
    // move_done
    output logic [0:0]  m_tuser
);

    htc_cmd_t    cmd;
    htc_status_t status;

    htc_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    htc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
